// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/jsu_pkg.sv -----
`timescale 1ns / 1ps

package jsu_pkg;

    // most bytes one input byte can produce
    localparam int unsigned MAX_BYTES = 6;
    localparam int unsigned CNT_W     = 3;

    // bundle queue between the scanner and the serializer
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = 2;
    localparam int unsigned Q_CNT_W = 3;

    // one input byte's worth of output: n bytes, n == 0 only for an end marker
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] data;
        logic [CNT_W-1:0]          n;
        logic                      done;
    } t_bundle;

    // up to four UTF-8 bytes and their count
    typedef struct packed {
        logic [3:0][7:0]  b;
        logic [CNT_W-1:0] n;
    } t_enc;

endpackage

// ----- hdl/jsu_front.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_in_byte,
    input  logic              i_is_last,
    input  logic              i_push_ready,
    output logic              o_push,
    output jsu_pkg::t_bundle  o_bundle
);

    localparam logic [2:0] MODE_TEXT   = 3'd0;
    localparam logic [2:0] MODE_ESC    = 3'd1;
    localparam logic [2:0] MODE_HEX    = 3'd2;
    localparam logic [2:0] MODE_HI_BS  = 3'd3;
    localparam logic [2:0] MODE_HI_U   = 3'd4;
    localparam logic [2:0] MODE_LO_HEX = 3'd5;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    function automatic logic [7:0] simple_escape(input logic [7:0] x);
        logic [7:0] y;
        case (x)
            CH_B:    y = 8'h08;
            CH_F:    y = 8'h0C;
            CH_N:    y = 8'h0A;
            CH_R:    y = 8'h0D;
            CH_T:    y = 8'h09;
            default: y = x;
        endcase
        return y;
    endfunction

    // bit 4 flags a non-hex character
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

    function automatic jsu_pkg::t_enc encode(input logic [20:0] cp);
        jsu_pkg::t_enc e;
        e = '0;
        if (cp < 21'h80) begin
            e.b[0] = cp[7:0];
            e.n    = 3'd1;
        end else if (cp < 21'h800) begin
            e.b[0] = {3'b110, cp[10:6]};
            e.b[1] = {2'b10, cp[5:0]};
            e.n    = 3'd2;
        end else if (cp < 21'h10000) begin
            e.b[0] = {4'b1110, cp[15:12]};
            e.b[1] = {2'b10, cp[11:6]};
            e.b[2] = {2'b10, cp[5:0]};
            e.n    = 3'd3;
        end else begin
            e.b[0] = {5'b11110, cp[20:18]};
            e.b[1] = {2'b10, cp[17:12]};
            e.b[2] = {2'b10, cp[11:6]};
            e.b[3] = {2'b10, cp[5:0]};
            e.n    = 3'd4;
        end
        return e;
    endfunction

    // re-read a short hex run as text at the end of the string
    function automatic jsu_pkg::t_enc replay(input logic [2:0][7:0] ch, input logic [1:0] n);
        jsu_pkg::t_enc e;
        logic          esc;
        e   = '0;
        esc = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < n) begin
                if (esc) begin
                    esc = 1'b0;
                    if (ch[i] != CH_U) begin
                        e.b[e.n[1:0]] = simple_escape(ch[i]);
                        e.n           = e.n + 3'd1;
                    end
                end else if (ch[i] == CH_BSLASH) begin
                    esc = 1'b1;
                end else begin
                    e.b[e.n[1:0]] = ch[i];
                    e.n           = e.n + 3'd1;
                end
            end
        end
        return e;
    endfunction

    logic [2:0]  r_mode, n_mode;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic        r_inv, n_inv;
    logic [9:0]  r_high, n_high;
    logic [15:0] r_rep, n_rep;

    logic          accept;
    logic [4:0]    hv;
    logic [15:0]   acc_take;
    logic [2:0]    cnt_take;
    logic          inv_take;
    logic [15:0]   rep_take;
    logic [2:0][7:0] rep_ch;
    logic [20:0]   pair_cp;
    logic          use_hi;
    jsu_pkg::t_enc enc_hi;
    jsu_pkg::t_enc enc_b;

    assign o_ready = i_push_ready;
    assign accept  = i_valid && i_push_ready;

    // hex run step shared by both digit modes
    assign hv       = hex_value(i_in_byte);
    assign acc_take = {r_acc[11:0], hv[4] ? 4'h0 : hv[3:0]};
    assign cnt_take = {1'b0, r_cnt} + 3'd1;
    assign inv_take = r_inv | hv[4];
    assign rep_take = (r_cnt == 2'd0) ? {r_rep[15:8], i_in_byte} :
                      (r_cnt == 2'd1) ? {i_in_byte, r_rep[7:0]} : r_rep;
    assign rep_ch   = {i_in_byte, rep_take};
    assign pair_cp  = {1'b0, r_high, acc_take[9:0]} + 21'h10000;
    assign enc_hi   = encode({5'b0, 6'b110110, r_high});

    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_inv  = r_inv;
        n_high = r_high;
        n_rep  = r_rep;
        use_hi = 1'b0;
        enc_b  = '0;
        unique case (r_mode)
            MODE_ESC: begin
                if (i_in_byte == CH_U) begin
                    n_mode = i_is_last ? MODE_TEXT : MODE_HEX;
                    n_acc  = '0;
                    n_cnt  = '0;
                    n_inv  = 1'b0;
                    n_rep  = '0;
                end else begin
                    enc_b.b[0] = simple_escape(i_in_byte);
                    enc_b.n    = 3'd1;
                    n_mode     = MODE_TEXT;
                end
            end
            MODE_HEX, MODE_LO_HEX: begin
                n_acc = acc_take;
                n_cnt = cnt_take[1:0];
                n_inv = inv_take;
                n_rep = rep_take;
                if (cnt_take == 3'd4) begin
                    if (r_mode == MODE_LO_HEX && !inv_take &&
                        acc_take >= 16'hDC00 && acc_take <= 16'hDFFF) begin
                        enc_b  = encode(pair_cp);
                        n_mode = MODE_TEXT;
                    end else begin
                        use_hi = (r_mode == MODE_LO_HEX);
                        n_mode = MODE_TEXT;
                        if (!inv_take) begin
                            if (acc_take >= 16'hD800 && acc_take <= 16'hDBFF && !i_is_last) begin
                                n_high = acc_take[9:0];
                                n_mode = MODE_HI_BS;
                            end else begin
                                enc_b = encode({5'b0, acc_take});
                            end
                        end
                    end
                end else if (i_is_last) begin
                    use_hi = (r_mode == MODE_LO_HEX);
                    enc_b  = replay(rep_ch, cnt_take[1:0]);
                end
            end
            MODE_HI_BS: begin
                if (i_in_byte == CH_BSLASH && !i_is_last) begin
                    n_mode = MODE_HI_U;
                end else begin
                    use_hi = 1'b1;
                    n_mode = MODE_TEXT;
                    if (i_in_byte != CH_BSLASH) begin
                        enc_b.b[0] = i_in_byte;
                        enc_b.n    = 3'd1;
                    end
                end
            end
            MODE_HI_U: begin
                if (i_in_byte == CH_U && !i_is_last) begin
                    n_mode = MODE_LO_HEX;
                    n_acc  = '0;
                    n_cnt  = '0;
                    n_inv  = 1'b0;
                    n_rep  = '0;
                end else begin
                    use_hi = 1'b1;
                    n_mode = MODE_TEXT;
                    if (i_in_byte != CH_U) begin
                        enc_b.b[0] = simple_escape(i_in_byte);
                        enc_b.n    = 3'd1;
                    end
                end
            end
            default: begin
                if (i_in_byte == CH_BSLASH) begin
                    n_mode = i_is_last ? MODE_TEXT : MODE_ESC;
                end else begin
                    enc_b.b[0] = i_in_byte;
                    enc_b.n    = 3'd1;
                end
            end
        endcase
        // end of string: back to the reset state
        if (i_is_last) begin
            n_mode = MODE_TEXT;
            n_acc  = '0;
            n_cnt  = '0;
            n_inv  = 1'b0;
            n_high = '0;
            n_rep  = '0;
        end
    end

    // lone high surrogate first, then whatever this byte adds
    always_comb begin
        o_bundle      = '0;
        o_bundle.done = i_is_last;
        if (use_hi) begin
            o_bundle.data[2:0] = enc_hi.b[2:0];
            o_bundle.data[5:3] = enc_b.b[2:0];
            o_bundle.n         = 3'd3 + enc_b.n;
        end else begin
            o_bundle.data[3:0] = enc_b.b;
            o_bundle.n         = enc_b.n;
        end
    end

    assign o_push = accept && (o_bundle.n != '0 || i_is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TEXT;
            r_acc  <= '0;
            r_cnt  <= '0;
            r_inv  <= 1'b0;
            r_high <= '0;
            r_rep  <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_inv  <= n_inv;
            r_high <= n_high;
            r_rep  <= n_rep;
        end
    end

    `ASSERT_NEXT(a_last_resets_mode, i_clk, i_rst_n, accept && i_is_last, r_mode == MODE_TEXT)
    `ASSERT_IMPL(a_last_always_pushes, i_clk, i_rst_n, accept && i_is_last, o_push)

endmodule

// ----- hdl/jsu_queue.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsu_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  jsu_pkg::t_bundle          i_bundle,
    output logic                      o_push_ready,
    input  logic                      i_pop,
    output logic                      o_head_valid,
    output jsu_pkg::t_bundle          o_head
);

    jsu_pkg::t_bundle r_mem [jsu_pkg::Q_DEPTH];

    logic [jsu_pkg::Q_PTR_W-1:0] r_wr, r_rd;
    logic [jsu_pkg::Q_CNT_W-1:0] r_count;
    logic                        do_pop;

    assign o_push_ready = (r_count != jsu_pkg::Q_CNT_W'(jsu_pkg::Q_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, o_push_ready)

endmodule

// ----- hdl/jsu_back.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  jsu_pkg::t_bundle i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic             o_run_last,
    output logic             o_string_done
);

    logic [jsu_pkg::CNT_W-1:0] r_idx;
    logic                      r_valid;
    logic [7:0]                r_byte;
    logic                      r_bvalid, r_run_last, r_done;

    logic load, marker, final_byte;

    assign load       = i_head_valid && (!r_valid || i_ready);
    assign marker     = (i_head.n == '0);
    assign final_byte = (r_idx == i_head.n - 1'b1);
    assign o_pop      = load && (marker || final_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (o_pop) begin
                r_idx <= '0;
            end else if (load) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte     <= marker ? 8'h00 : i_head.data[r_idx];
            r_bvalid   <= !marker;
            r_run_last <= marker || final_byte;
            r_done     <= (marker || final_byte) && i_head.done;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_byte_valid  = r_bvalid;
    assign o_run_last    = r_run_last;
    assign o_string_done = r_done;

    `ASSERT_IMPL(a_marker_ends_string, i_clk, i_rst_n, r_valid && !r_bvalid,
                 r_run_last && r_done && r_byte == 8'h00)
    `ASSERT_IMPL(a_done_on_run_last, i_clk, i_rst_n, r_valid && r_done, r_run_last)
    `ASSERT_IMPL(a_idx_in_bundle, i_clk, i_rst_n, i_head_valid && !marker,
                 r_idx < i_head.n)

endmodule

// ----- hdl/json_string_unescape_utf8_core.sv -----
`timescale 1ns / 1ps

// JSON string unescaper: content bytes of a quoted string in, UTF-8 bytes out.
// Input channel (i_valid / o_ready): one string byte per beat, i_is_last on the
// final byte. Output channel (o_valid / i_ready): one result per beat; every
// input byte that yields bytes ends with o_run_last set, the final input byte
// always yields at least one beat (an end marker with o_byte_valid low when it
// produces no data) and that beat carries o_string_done.
// When the output side is free, a result is written into the bundle queue and
// then into the output register; the scan itself is combinational.
// Throughput: one input beat per cycle while i_ready stays high and each byte
// yields at most one output byte; a byte yielding several takes one output
// beat per byte (up to six: a lone high surrogate plus a following escape).
// The four-entry bundle queue absorbs such bursts before the input stalls.
// Reset (synchronous, i_rst_n low) returns the scanner to text mode and empties
// the queue and output register. When the receiver holds i_ready low the
// result beat holds and the queue fills; o_ready drops only when it is full.

module json_string_unescape_utf8_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_run_last,
    output logic       o_string_done
);

    logic             push, push_ready, pop, head_valid;
    jsu_pkg::t_bundle push_bundle, head;

    // scan escapes into byte bundles, one beat per cycle while the queue has room
    jsu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .i_is_last    (i_is_last),
        .i_push_ready (push_ready),
        .o_push       (push),
        .o_bundle     (push_bundle)
    );

    // decouple the scanner from output stalls
    jsu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_bundle     (push_bundle),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // serialize each bundle one byte per beat into the output register
    jsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done)
    );

endmodule
